// ===== rtl/core/cbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

	// nibble ram geometry
	localparam int NIB_DEPTH  = 512;
	localparam int NIB_AW     = $clog2(NIB_DEPTH);

	// largest rom bank count the select logic honors
	localparam int MAX_ROM_BANKS = 128;
	localparam logic [6:0] MAX_BANK_MASK = 7'(MAX_ROM_BANKS - 1);

	// controller kinds
	localparam logic [1:0] KIND_MBC1 = 2'd0;
	localparam logic [1:0] KIND_MBC2 = 2'd1;
	localparam logic [1:0] KIND_MBC3 = 2'd2;

	// configuration register indexes
	localparam logic CFG_KIND       = 1'b0;
	localparam logic CFG_BANK_COUNT = 1'b1;

	// result targets
	localparam logic [2:0] TGT_ROM    = 3'd0;
	localparam logic [2:0] TGT_EXRAM  = 3'd1;
	localparam logic [2:0] TGT_NIBBLE = 3'd2;
	localparam logic [2:0] TGT_OTHER  = 3'd3;
	localparam logic [2:0] TGT_NONE   = 3'd4;

	// source of the read data byte
	typedef enum logic [1:0] {
		RD_ZERO,
		RD_ONES,
		RD_NIBBLE
	} rd_kind_t;

	typedef struct packed {
		logic        op;
		logic [15:0] address;
		logic [7:0]  data;
	} req_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [20:0] phys_addr;
		logic        is_write;
		logic [7:0]  read_data;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/cbc_nibble_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbc_nibble_ram
	import cbc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [NIB_AW-1:0] addr,
	input  wire logic [3:0]        wdata,
	output logic      [3:0]        rdata,
	output logic                   busy
);

	logic [3:0]        mem [NIB_DEPTH];
	logic [NIB_AW-1:0] clr_idx_q;
	logic              clr_busy_q;
	logic [3:0]        rdata_q;

	// clearing sweep after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == NIB_AW'(NIB_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// write port, shared by the sweep and item writes
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= 4'h0;
		end else if (en && we) begin
			mem[addr] <= wdata;
		end
	end

	// registered read, held until the next read
	always_ff @(posedge clk) begin
		if (en && !we) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

`default_nettype wire

// ===== rtl/core/cartridge_bank_controller_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bank controller for MBC1, MBC2 and MBC3 style cartridges.
// The req channel carries one CPU bus access per item (op, address, data);
// the rsp channel returns one item per access: target region, physical
// ROM or external RAM address, write flag and read data byte.
// Writes below 0x8000 update the bank registers when the item is accepted,
// so the next item already sees the new banking.
// rsp_valid rises once the item has passed stage one into the output register;
// the result is held there until taken. One item is taken every cycle while
// req_stall is low; the MBC2 nibble RAM is a single port memory read or written
// once per item, and its registered read sets the two stage depth.
// A stalled rsp holds its item in the output register; the first stage can
// still take one item, and req_stall rises once both stages are full.
// After reset the nibble RAM is swept to zero, one entry a cycle, over all 512
// entries; req_stall stays high during the sweep. Configuration writes
// (cfg_we, cfg_index, cfg_data) are taken at any time, reset leaves the
// MBC3 kind and 128 banks selected.
module cartridge_bank_controller_unit
	import cbc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_t            rsp
);

	logic [1:0] kind_q;
	logic [7:0] count_q;
	logic [6:0] rom_low_q;
	logic [1:0] ram_bank_q;
	logic [1:0] ram_latch_q;
	logic [1:0] rom_high_q;
	logic [1:0] high_latch_q;
	logic       mode_q;
	logic       ram_en_q;

	logic [6:0] rom_low_d;
	logic [1:0] ram_bank_d;
	logic [1:0] ram_latch_d;
	logic [1:0] rom_high_d;
	logic [1:0] high_latch_d;
	logic       mode_d;
	logic       ram_en_d;

	logic [7:0] count_m1;
	logic [6:0] mask;
	logic       acc;
	logic       adv1;
	logic       adv2;
	logic       is_mbc1;
	logic       is_mbc2;
	logic       enable_code;
	logic [6:0] rom_bank;

	logic [2:0]  tgt_c;
	logic [20:0] phys_c;
	logic        isw_c;
	rd_kind_t    rdk_c;
	logic        nib_en;
	logic        nib_we;
	logic [3:0]  nib_rdata;
	logic        nib_busy;

	logic        v_s1;
	logic [2:0]  tgt_s1;
	logic [20:0] phys_s1;
	logic        isw_s1;
	rd_kind_t    rdk_s1;
	logic        v_s2;
	rsp_t        rsp_s2;

	function automatic logic [6:0] pick_bank(input logic [6:0] v, input logic [6:0] m);
		logic [6:0] b;
		b = (v == 7'd0) ? 7'd1 : v;
		return b & m;
	endfunction

	// bank mask from the configured count
	assign count_m1 = count_q - 8'd1;
	assign mask     = count_m1[6:0] & MAX_BANK_MASK;
	assign is_mbc1  = (kind_q == KIND_MBC1);
	assign is_mbc2  = (kind_q == KIND_MBC2);
	assign enable_code = (req.data[3:0] == 4'hA);

	// handshake
	assign adv2      = !v_s2 || !rsp_stall;
	assign adv1      = !v_s1 || adv2;
	assign req_stall = nib_busy || !adv1;
	assign acc       = req_valid && !req_stall;

	// switchable rom bank
	always_comb begin
		rom_bank = rom_low_q;
		if (is_mbc1) begin
			rom_bank = rom_low_q | {rom_high_q, 5'd0};
		end
		rom_bank = rom_bank & mask;
	end

	// access decode and register update
	always_comb begin
		tgt_c        = TGT_NONE;
		phys_c       = '0;
		isw_c        = 1'b0;
		rdk_c        = RD_ZERO;
		nib_en       = 1'b0;
		nib_we       = 1'b0;
		rom_low_d    = rom_low_q;
		ram_bank_d   = ram_bank_q;
		ram_latch_d  = ram_latch_q;
		rom_high_d   = rom_high_q;
		high_latch_d = high_latch_q;
		mode_d       = mode_q;
		ram_en_d     = ram_en_q;
		if (!req.address[15]) begin
			if (req.op) begin
				if (is_mbc2) begin
					if (!req.address[14]) begin
						if (!req.address[8]) begin
							ram_en_d = enable_code;
						end else begin
							rom_low_d = pick_bank({3'd0, req.data[3:0]}, mask);
						end
					end
				end else begin
					case (req.address[14:13])
						2'b00: ram_en_d = enable_code;
						2'b01: begin
							if (is_mbc1) begin
								rom_low_d = pick_bank({2'd0, req.data[4:0]}, mask);
							end else begin
								rom_low_d = pick_bank(req.data[6:0], mask);
							end
						end
						2'b10: begin
							if (!is_mbc1) begin
								ram_bank_d = req.data[1:0];
							end else if (!mode_q) begin
								rom_high_d   = req.data[1:0];
								high_latch_d = req.data[1:0];
							end else begin
								ram_bank_d  = req.data[1:0];
								ram_latch_d = req.data[1:0];
							end
						end
						default: begin
							if (is_mbc1) begin
								mode_d = req.data[0];
								if (!req.data[0]) begin
									ram_bank_d = 2'd0;
									rom_high_d = high_latch_q;
								end else begin
									rom_high_d = 2'd0;
									ram_bank_d = ram_latch_q;
								end
							end
						end
					endcase
				end
			end else if (!req.address[14]) begin
				tgt_c  = TGT_ROM;
				phys_c = {5'd0, req.address};
			end else begin
				tgt_c  = TGT_ROM;
				phys_c = {rom_bank, req.address[13:0]};
			end
		end else if (req.address[15:13] == 3'b101) begin
			if (!ram_en_q) begin
				rdk_c = req.op ? RD_ZERO : RD_ONES;
			end else if (is_mbc2) begin
				if (req.address[12:9] == 4'd0) begin
					tgt_c  = TGT_NIBBLE;
					nib_en = 1'b1;
					nib_we = req.op;
					isw_c  = req.op;
					rdk_c  = req.op ? RD_ZERO : RD_NIBBLE;
				end
			end else begin
				tgt_c  = TGT_EXRAM;
				phys_c = {6'd0, ram_bank_q, req.address[12:0]};
				isw_c  = req.op;
			end
		end else begin
			tgt_c = TGT_OTHER;
			isw_c = req.op;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_MBC3;
			count_q <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KIND:       kind_q  <= cfg_data[1:0];
				CFG_BANK_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// bank registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_low_q    <= 7'd1;
			ram_bank_q   <= 2'd0;
			ram_latch_q  <= 2'd0;
			rom_high_q   <= 2'd0;
			high_latch_q <= 2'd0;
			mode_q       <= 1'b0;
			ram_en_q     <= 1'b0;
		end else if (acc) begin
			rom_low_q    <= rom_low_d;
			ram_bank_q   <= ram_bank_d;
			ram_latch_q  <= ram_latch_d;
			rom_high_q   <= rom_high_d;
			high_latch_q <= high_latch_d;
			mode_q       <= mode_d;
			ram_en_q     <= ram_en_d;
		end
	end

	cbc_nibble_ram u_nib (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (acc && nib_en),
		.we    (nib_we),
		.addr  (req.address[NIB_AW-1:0]),
		.wdata (req.data[3:0]),
		.rdata (nib_rdata),
		.busy  (nib_busy)
	);

	// stage one: decoded item alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tgt_s1  <= tgt_c;
			phys_s1 <= phys_c;
			isw_s1  <= isw_c;
			rdk_s1  <= rdk_c;
		end
	end

	// stage two: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			rsp_s2.target    <= tgt_s1;
			rsp_s2.phys_addr <= phys_s1;
			rsp_s2.is_write  <= isw_s1;
			case (rdk_s1)
				RD_ONES:   rsp_s2.read_data <= 8'hFF;
				RD_NIBBLE: rsp_s2.read_data <= {4'h0, nib_rdata};
				default:   rsp_s2.read_data <= 8'h00;
			endcase
		end
	end

	assign rsp_valid = v_s2;
	assign rsp       = rsp_s2;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cbc_pkg::*;

	localparam logic       OP_READ     = 1'b0;
	localparam logic       OP_WRITE    = 1'b1;
	localparam logic [1:0] KIND_SPARE  = 2'd3;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         HOLD_CYCLES = 300;

	// banking state and expected responses, kept in access order
	class access_checker;
		logic [1:0] kind;
		logic [7:0] bank_count;
		logic [6:0] rom_bank_low;
		logic [1:0] ram_bank;
		logic [1:0] ram_bank_latch;
		logic [1:0] rom_high_bits;
		logic [1:0] rom_high_latch;
		logic       layout_mode;
		logic       ram_enabled;
		logic [3:0] nibbles [NIB_DEPTH];
		rsp_t       pending [$];
		int         errors;
		int         checked;

		function new();
			kind           = KIND_MBC3;
			bank_count     = 8'd128;
			rom_bank_low   = 7'd1;
			ram_bank       = 2'd0;
			ram_bank_latch = 2'd0;
			rom_high_bits  = 2'd0;
			rom_high_latch = 2'd0;
			layout_mode    = 1'b0;
			ram_enabled    = 1'b0;
			foreach (nibbles[i]) nibbles[i] = 4'h0;
			errors  = 0;
			checked = 0;
		endfunction

		function void set_register(logic idx, logic [7:0] value);
			if (idx == CFG_KIND)
				kind = value[1:0];
			else
				bank_count = value;
		endfunction

		// count minus one, wrapping at eight bits, limited to seven
		function logic [6:0] bank_mask();
			logic [7:0] m;
			m = bank_count - 8'd1;
			return m[6:0] & MAX_BANK_MASK;
		endfunction

		// a zero select reads as one, then the bank count masks it
		function logic [6:0] select_bank(logic [6:0] v);
			return ((v == 7'd0) ? 7'd1 : v) & bank_mask();
		endfunction

		function void write_register(logic [15:0] addr, logic [7:0] d);
			logic enable;
			enable = (d[3:0] == 4'hA);
			if (kind == KIND_MBC2) begin
				if (addr < 16'h4000) begin
					if (!addr[8])
						ram_enabled = enable;
					else
						rom_bank_low = select_bank({3'b0, d[3:0]});
				end
			end else if (addr < 16'h2000) begin
				ram_enabled = enable;
			end else if (addr < 16'h4000) begin
				if (kind == KIND_MBC1)
					rom_bank_low = select_bank({2'b0, d[4:0]});
				else
					rom_bank_low = select_bank(d[6:0]);
			end else if (addr < 16'h6000) begin
				if (kind != KIND_MBC1) begin
					ram_bank = d[1:0];
				end else if (!layout_mode) begin
					rom_high_bits  = d[1:0];
					rom_high_latch = d[1:0];
				end else begin
					ram_bank       = d[1:0];
					ram_bank_latch = d[1:0];
				end
			end else if (kind == KIND_MBC1) begin
				layout_mode = d[0];
				if (!layout_mode) begin
					ram_bank      = 2'd0;
					rom_high_bits = rom_high_latch;
				end else begin
					rom_high_bits = 2'd0;
					ram_bank      = ram_bank_latch;
				end
			end
		endfunction

		// work out the response of one accepted access and update the banking
		function void note_access(req_t a);
			rsp_t       e;
			logic [6:0] bank;
			e = '0;
			e.target = TGT_NONE;
			if (a.address < 16'h8000) begin
				if (a.op == OP_WRITE) begin
					write_register(a.address, a.data);
				end else if (a.address < 16'h4000) begin
					e.target    = TGT_ROM;
					e.phys_addr = 21'(a.address);
				end else begin
					bank = rom_bank_low;
					if (kind == KIND_MBC1)
						bank = bank | {rom_high_bits, 5'b0};
					bank = bank & bank_mask();
					e.target    = TGT_ROM;
					e.phys_addr = {bank, a.address[13:0]};
				end
			end else if (a.address >= 16'hA000 && a.address < 16'hC000) begin
				if (!ram_enabled) begin
					e.read_data = (a.op == OP_WRITE) ? 8'h00 : 8'hFF;
				end else if (kind == KIND_MBC2) begin
					if (a.address < 16'hA200) begin
						e.target = TGT_NIBBLE;
						if (a.op == OP_WRITE) begin
							nibbles[a.address[NIB_AW-1:0]] = a.data[3:0];
							e.is_write = 1'b1;
						end else begin
							e.read_data = {4'h0, nibbles[a.address[NIB_AW-1:0]]};
						end
					end
				end else begin
					e.target    = TGT_EXRAM;
					e.phys_addr = 21'({ram_bank, a.address[12:0]});
					e.is_write  = a.op;
				end
			end else begin
				e.target   = TGT_OTHER;
				e.is_write = a.op;
			end
			pending.push_back(e);
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: item %0d: %s", checked, msg);
		endtask

		task check_rsp(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				report($sformatf("response with none outstanding (%h)", got));
				return;
			end
			want = pending.pop_front();
			if (got.target !== want.target)
				report($sformatf("target %0d, want %0d", got.target, want.target));
			if (got.phys_addr !== want.phys_addr)
				report($sformatf("phys_addr %h, want %h", got.phys_addr, want.phys_addr));
			if (got.is_write !== want.is_write)
				report($sformatf("is_write %b, want %b", got.is_write, want.is_write));
			if (got.read_data !== want.read_data)
				report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
			checked++;
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;
	logic       req_valid;
	logic       req_stall;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_stall;
	rsp_t       rsp;

	access_checker board = new();
	int            req_gap_pct   = 18;
	int            rsp_stall_pct = 18;
	bit            hold_off_req  = 1'b0;
	int            cycle_count   = 0;

	cartridge_bank_controller_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// response side: random stalls, plus one long hold-off on request
	initial begin
		rsp_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
				@(posedge clk);
			end
		end
	end

	// compare every accepted response
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_rsp(rsp);
	end

	function automatic req_t acc(logic op, logic [15:0] address, logic [7:0] data);
		req_t a;
		a.op      = op;
		a.address = address;
		a.data    = data;
		return a;
	endfunction

	// mostly well formed bank setup and memory traffic, some plain noise
	function automatic req_t random_access(logic [1:0] kind);
		req_t a;
		int   pick;
		a.op      = 1'($urandom_range(1));
		a.address = 16'($urandom_range(16'hFFFF));
		a.data    = 8'($urandom_range(255));
		pick      = $urandom_range(99);
		if (pick < 14) begin
			// ram enable, mostly the enabling pattern
			a.op      = OP_WRITE;
			a.address = 16'($urandom_range(16'h1FFF));
			if ($urandom_range(3) != 0)
				a.data[3:0] = 4'hA;
		end else if (pick < 24) begin
			// rom bank select, sometimes a zero select
			a.op      = OP_WRITE;
			a.address = 16'($urandom_range(16'h3FFF, 16'h2000));
			if ($urandom_range(7) == 0)
				a.data[6:0] = 7'd0;
		end else if (pick < 32) begin
			a.op      = OP_WRITE;
			a.address = 16'($urandom_range(16'h5FFF, 16'h4000));
		end else if (pick < 38) begin
			a.op      = OP_WRITE;
			a.address = 16'($urandom_range(16'h7FFF, 16'h6000));
		end else if (pick < 58) begin
			a.op      = OP_READ;
			a.address = 16'($urandom_range(16'h7FFF));
		end else if (pick < 84) begin
			// cartridge ram, mostly the nibble window on the mbc2
			if (kind == KIND_MBC2 && $urandom_range(3) != 0)
				a.address = 16'($urandom_range(16'hA1FF, 16'hA000));
			else
				a.address = 16'($urandom_range(16'hBFFF, 16'hA000));
		end else if (pick < 92) begin
			if ($urandom_range(1) == 0)
				a.address = 16'($urandom_range(16'h9FFF, 16'h8000));
			else
				a.address = 16'($urandom_range(16'hFFFF, 16'hC000));
		end
		return a;
	endfunction

	// offer one item, with random gaps, until it is taken
	task automatic send_access(req_t a);
		while ($urandom_range(99) < req_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= a;
		do @(posedge clk); while (req_stall);
		board.note_access(a);
	endtask

	// let every outstanding response come back
	task automatic drain();
		req_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_controller(logic [1:0] kind, logic [7:0] count);
		logic [7:0] kind_word;
		kind_word = {6'($urandom_range(63)), kind};
		cfg_we    <= 1'b1;
		cfg_index <= CFG_KIND;
		cfg_data  <= kind_word;
		@(posedge clk);
		cfg_index <= CFG_BANK_COUNT;
		cfg_data  <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_register(CFG_KIND, kind_word);
		board.set_register(CFG_BANK_COUNT, count);
	endtask

	task automatic run_phase(logic [1:0] kind, logic [7:0] count, int n, int gap, int stall,
			bit hold);
		drain();
		set_controller(kind, count);
		req_gap_pct   = gap;
		rsp_stall_pct = stall;
		if (hold)
			hold_off_req = 1'b1;
		repeat (n) send_access(random_access(kind));
	endtask

	// stimulus
	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_KIND;
		cfg_data  <= 8'd0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset banking: mbc3, 128 banks, ram disabled
		send_access(acc(OP_READ, 16'h0000, 8'h00));
		send_access(acc(OP_READ, 16'h3FFF, 8'hFF));
		send_access(acc(OP_READ, 16'h4000, 8'h00));
		send_access(acc(OP_READ, 16'hA000, 8'h00));
		send_access(acc(OP_WRITE, 16'hBFFF, 8'hFF));
		send_access(acc(OP_WRITE, 16'h0000, 8'h0A));
		send_access(acc(OP_WRITE, 16'h2000, 8'h00));
		send_access(acc(OP_WRITE, 16'h3FFF, 8'hFF));
		send_access(acc(OP_READ, 16'h7FFF, 8'h00));
		send_access(acc(OP_WRITE, 16'h4000, 8'h03));
		send_access(acc(OP_WRITE, 16'hBFFF, 8'hA5));
		send_access(acc(OP_READ, 16'hA000, 8'h00));
		send_access(acc(OP_WRITE, 16'h6000, 8'hFF));
		send_access(acc(OP_READ, 16'h8000, 8'h00));
		send_access(acc(OP_WRITE, 16'hFFFF, 8'h5A));
		send_access(acc(OP_WRITE, 16'h1FFF, 8'h0B));
		send_access(acc(OP_READ, 16'hB000, 8'h00));

		// mbc2 nibble ram and its bank select
		drain();
		set_controller(KIND_MBC2, 8'd16);
		send_access(acc(OP_WRITE, 16'h0000, 8'hFA));
		send_access(acc(OP_WRITE, 16'h0100, 8'h00));
		send_access(acc(OP_WRITE, 16'hA1FF, 8'hFF));
		send_access(acc(OP_READ, 16'hA1FF, 8'h00));
		send_access(acc(OP_WRITE, 16'hA200, 8'hFF));
		send_access(acc(OP_READ, 16'hBFFF, 8'h00));

		// random traffic over several controller settings
		run_phase(KIND_MBC1, 8'd128, 110, 18, 18, 1'b0);
		run_phase(KIND_MBC1, 8'd2, 100, 18, 18, 1'b0);
		run_phase(KIND_MBC2, 8'd16, 100, 18, 18, 1'b0);
		run_phase(KIND_MBC3, 8'd128, 150, 0, 0, 1'b1);
		run_phase(KIND_MBC1, 8'd32, 100, 0, 0, 1'b0);
		run_phase(KIND_SPARE, 8'd64, 100, 18, 18, 1'b0);
		run_phase(KIND_MBC1, 8'd0, 100, 18, 18, 1'b0);
		run_phase(KIND_MBC2, 8'd2, 100, 18, 18, 1'b0);
		run_phase(KIND_MBC3, 8'd255, 100, 18, 18, 1'b0);
		run_phase(KIND_MBC1, 8'd100, 100, 18, 18, 1'b0);
		run_phase(KIND_MBC2, 8'd128, 100, 18, 18, 1'b0);
		run_phase(KIND_MBC3, 8'd3, 100, 18, 18, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/cbc_pkg.sv
rtl/core/cbc_nibble_ram.sv
rtl/core/cartridge_bank_controller_unit.sv
bench/testbench.sv
